[design/ttc_pkg.sv]
// Shared constants, payload types and codes for the translational triple classifier.
package ttc_pkg;

   localparam int DIM       = 128;
   localparam int ENTITIES  = 16384;
   localparam int RELATIONS = 256;

   localparam int DIST_W = 24;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
   localparam int ELEM_W = 16;
   localparam int DIFF_W = ELEM_W + 2;
   localparam int ABS_W  = ELEM_W + 1;
   localparam int DIM_LOG = $clog2(DIM);
   localparam int ACC_W  = DIST_W + DIM_LOG;
   localparam int CNT_W  = $clog2(DIM + 1);
   localparam int ENT_AW  = (ENTITIES * DIM > 1) ? $clog2(ENTITIES * DIM) : 1;
   localparam int REL_TAW = (RELATIONS * DIM > 1) ? $clog2(RELATIONS * DIM) : 1;
   localparam int REL_AW  = (RELATIONS > 1) ? $clog2(RELATIONS) : 1;
   localparam int COUNT_W = 32;

   typedef logic signed [ELEM_W-1:0] elem_type;

   typedef enum logic [2:0] {
      CMD_WRITE_ENTITY    = 3'd0,
      CMD_WRITE_RELATION  = 3'd1,
      CMD_WRITE_THRESHOLD = 3'd2,
      CMD_CLASSIFY        = 3'd3,
      CMD_READ_STAT       = 3'd4,
      CMD_CLEAR_STATS     = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      SEL_TP  = 3'd0,
      SEL_FN  = 3'd1,
      SEL_TN  = 3'd2,
      SEL_FP  = 3'd3,
      SEL_MAX = 3'd4,
      SEL_MIN = 3'd5
   } sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RUN,
      ST_DRAIN,
      ST_CHECK,
      ST_UPDATE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [2:0]        command;
      logic [13:0]       head;
      logic [13:0]       tail;
      logic [7:0]        relation;
      logic [6:0]        element;
      logic signed [15:0] embed_value;
      logic [23:0]       threshold_value;
      logic              is_positive;
      logic [2:0]        stat_select;
   } req_type;

   typedef struct packed {
      logic [23:0] distance;
      logic        accepted;
      logic [31:0] stat_value;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] tp;
      logic [COUNT_W-1:0] fn;
      logic [COUNT_W-1:0] tn;
      logic [COUNT_W-1:0] fp;
      logic [DIST_W-1:0]  max_dist;
      logic [DIST_W-1:0]  min_dist;
   } stat_row_type;

   localparam stat_row_type ROW_RESET = '{
      tp: '0, fn: '0, tn: '0, fp: '0, max_dist: '0, min_dist: DIST_MAX
   };

   typedef struct packed {
      logic clear;
      logic valid;
   } dist_ctl_type;

endpackage

[design/ttc_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM.
module ttc_ram #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/ttc_ram_2r.sv]
// Generic synchronous RAM with one write port and two read ports.
module ttc_ram_2r #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

[design/ttc_dist.sv]
// L1 distance accumulator: per-element difference, magnitude and saturating sum.
module ttc_dist (
   input  logic                     clock,
   input  logic                     reset,
   input  ttc_pkg::dist_ctl_type    ctl,
   input  ttc_pkg::elem_type        head_elem,
   input  ttc_pkg::elem_type        rel_elem,
   input  ttc_pkg::elem_type        tail_elem,
   output logic                     busy,
   output logic [ttc_pkg::DIST_W-1:0] distance
);
   import ttc_pkg::*;

   logic signed [DIFF_W-1:0] diff_in;
   logic signed [DIFF_W-1:0] diff_ff;
   logic                     diff_valid_ff;
   logic [ABS_W-1:0]         mag;
   logic [ACC_W-1:0]         acc_ff;
   logic [ACC_W-1:0]         acc_in;

   assign diff_in = DIFF_W'(head_elem) + DIFF_W'(rel_elem) - DIFF_W'(tail_elem);
   assign mag     = diff_ff[DIFF_W-1] ? ABS_W'(-diff_ff) : ABS_W'(diff_ff);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (diff_valid_ff) begin
         acc_in = acc_ff + ACC_W'(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_valid_ff <= 1'b0;
      end else begin
         diff_valid_ff <= ctl.valid && !ctl.clear;
      end
      diff_ff <= diff_in;
      acc_ff  <= acc_in;
   end

   assign busy     = diff_valid_ff;
   assign distance = (acc_ff > ACC_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(acc_ff);

endmodule

[design/translational_triple_classifier.sv]
// Top level of the translational triple classifier: control sequencer and state memories.
//
// Every transaction yields one result. During a classify sweep the entity memory delivers
// the head and tail elements and the relation memory the relation element once per cycle.
// The threshold and statistics row are read when the request is taken; after the sweep
// the accumulator drains, the distance is checked against the threshold and the row is
// written back. Other commands go from the execute state to the output state. A new
// transaction is taken once the previous one has handed its result to the output register.
module translational_triple_classifier (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ttc_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ttc_pkg::rsp_type  rsp_payload,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);
   import ttc_pkg::*;

   state_type          state_ff, state_in;
   req_type            item_ff;
   logic [ENT_AW-1:0]  h_base_ff, t_base_ff;
   logic [REL_TAW-1:0] r_base_ff;
   logic               head_ok_ff, tail_ok_ff, rel_ok_ff;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               rd_valid_ff;
   logic               track_range_ff;
   logic [RELATIONS-1:0] thr_valid_ff, thr_valid_in;
   logic [RELATIONS-1:0] stat_valid_ff, stat_valid_in;
   rsp_type            pend_ff, pend_in;
   logic               accept_ff, accept_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic               load_rsp;

   logic               take;
   logic [REL_AW-1:0]  rel_idx;
   logic               elem_ok;

   logic               ent_wr_en, rel_wr_en, thr_wr_en, stat_wr_en;
   logic               ent_rd_en;
   logic [ENT_AW-1:0]  ent_wr_addr, ent_rd_addr_h, ent_rd_addr_t;
   logic [REL_TAW-1:0] rel_wr_addr, rel_rd_addr;
   elem_type           ent_rdata_h, ent_rdata_t, rel_rdata;
   logic [DIST_W-1:0]  thr_rdata, thr_cur;
   stat_row_type       stat_rdata, row_cur, stat_wr_data;

   dist_ctl_type       dist_ctl;
   logic               dist_busy;
   logic [DIST_W-1:0]  sweep_dist;
   elem_type           h_elem, r_elem, t_elem;
   logic               hit;

   assign take      = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rel_idx   = REL_AW'(item_ff.relation);
   assign elem_ok   = 32'(item_ff.element) < DIM;

   assign ent_wr_addr   = h_base_ff + ENT_AW'(item_ff.element);
   assign ent_rd_addr_h = h_base_ff + ENT_AW'(idx_ff);
   assign ent_rd_addr_t = t_base_ff + ENT_AW'(idx_ff);
   assign rel_wr_addr   = r_base_ff + REL_TAW'(item_ff.element);
   assign rel_rd_addr   = r_base_ff + REL_TAW'(idx_ff);

   assign thr_cur = thr_valid_ff[rel_idx] ? thr_rdata : '0;
   assign row_cur = stat_valid_ff[rel_idx] ? stat_rdata : ROW_RESET;

   assign h_elem = head_ok_ff ? ent_rdata_h : '0;
   assign t_elem = tail_ok_ff ? ent_rdata_t : '0;
   assign r_elem = rel_ok_ff ? rel_rdata : '0;
   assign hit    = rel_ok_ff && (sweep_dist < thr_cur);

   ttc_ram_2r #(.DEPTH(ENTITIES * DIM), .WIDTH(ELEM_W)) u_entity_mem (
      .clock     (clock),
      .wr_en     (ent_wr_en),
      .wr_addr   (ent_wr_addr),
      .wr_data   (item_ff.embed_value),
      .rd_en     (ent_rd_en),
      .rd_addr_a (ent_rd_addr_h),
      .rd_addr_b (ent_rd_addr_t),
      .rd_data_a (ent_rdata_h),
      .rd_data_b (ent_rdata_t)
   );

   ttc_ram #(.DEPTH(RELATIONS * DIM), .WIDTH(ELEM_W)) u_relation_mem (
      .clock   (clock),
      .wr_en   (rel_wr_en),
      .wr_addr (rel_wr_addr),
      .wr_data (item_ff.embed_value),
      .rd_en   (ent_rd_en),
      .rd_addr (rel_rd_addr),
      .rd_data (rel_rdata)
   );

   ttc_ram #(.DEPTH(RELATIONS), .WIDTH(DIST_W)) u_threshold_mem (
      .clock   (clock),
      .wr_en   (thr_wr_en),
      .wr_addr (rel_idx),
      .wr_data (item_ff.threshold_value),
      .rd_en   (take),
      .rd_addr (REL_AW'(req_payload.relation)),
      .rd_data (thr_rdata)
   );

   ttc_ram #(.DEPTH(RELATIONS), .WIDTH($bits(stat_row_type))) u_stat_mem (
      .clock   (clock),
      .wr_en   (stat_wr_en),
      .wr_addr (rel_idx),
      .wr_data (stat_wr_data),
      .rd_en   (take),
      .rd_addr (REL_AW'(req_payload.relation)),
      .rd_data (stat_rdata)
   );

   ttc_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dist_ctl),
      .head_elem (h_elem),
      .rel_elem  (r_elem),
      .tail_elem (t_elem),
      .busy      (dist_busy),
      .distance  (sweep_dist)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      ent_wr_en     = 1'b0;
      rel_wr_en     = 1'b0;
      thr_wr_en     = 1'b0;
      stat_wr_en    = 1'b0;
      stat_wr_data  = row_cur;
      ent_rd_en     = 1'b0;
      pend_in       = pend_ff;
      accept_in     = accept_ff;
      load_rsp      = 1'b0;
      thr_valid_in  = thr_valid_ff;
      stat_valid_in = stat_valid_ff;
      dist_ctl.clear = 1'b0;
      dist_ctl.valid = rd_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            pend_in  = '0;
            state_in = ST_OUT;
            case (cmd_type'(item_ff.command))
               CMD_WRITE_ENTITY: begin
                  ent_wr_en = head_ok_ff && elem_ok;
               end
               CMD_WRITE_RELATION: begin
                  rel_wr_en = rel_ok_ff && elem_ok;
               end
               CMD_WRITE_THRESHOLD: begin
                  if (rel_ok_ff) begin
                     thr_wr_en             = 1'b1;
                     thr_valid_in[rel_idx] = 1'b1;
                  end
               end
               CMD_CLASSIFY: begin
                  dist_ctl.clear = 1'b1;
                  idx_in         = '0;
                  state_in       = ST_RUN;
               end
               CMD_READ_STAT: begin
                  if (rel_ok_ff) begin
                     case (sel_type'(item_ff.stat_select))
                        SEL_TP:  pend_in.stat_value = row_cur.tp;
                        SEL_FN:  pend_in.stat_value = row_cur.fn;
                        SEL_TN:  pend_in.stat_value = row_cur.tn;
                        SEL_FP:  pend_in.stat_value = row_cur.fp;
                        SEL_MAX: pend_in.stat_value = 32'(row_cur.max_dist);
                        SEL_MIN: pend_in.stat_value = 32'(row_cur.min_dist);
                        default: pend_in.stat_value = '0;
                     endcase
                  end
               end
               CMD_CLEAR_STATS: begin
                  if (rel_ok_ff) begin
                     stat_wr_en             = 1'b1;
                     stat_wr_data           = ROW_RESET;
                     stat_valid_in[rel_idx] = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_RUN: begin
            ent_rd_en = 1'b1;
            idx_in    = idx_ff + CNT_W'(1);
            if (idx_ff == CNT_W'(DIM - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !dist_busy) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            pend_in.distance = sweep_dist;
            pend_in.accepted = hit;
            accept_in        = hit;
            state_in         = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (rel_ok_ff) begin
               stat_wr_en = 1'b1;
               if (item_ff.is_positive) begin
                  if (accept_ff) begin
                     stat_wr_data.tp = row_cur.tp + COUNT_W'(1);
                  end else begin
                     stat_wr_data.fn = row_cur.fn + COUNT_W'(1);
                  end
               end else begin
                  if (accept_ff) begin
                     stat_wr_data.fp = row_cur.fp + COUNT_W'(1);
                  end else begin
                     stat_wr_data.tn = row_cur.tn + COUNT_W'(1);
                  end
               end
               if (track_range_ff) begin
                  if (pend_ff.distance > row_cur.max_dist) begin
                     stat_wr_data.max_dist = pend_ff.distance;
                  end
                  if (pend_ff.distance < row_cur.min_dist) begin
                     stat_wr_data.min_dist = pend_ff.distance;
                  end
               end
               stat_valid_in[rel_idx] = 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rd_valid_ff    <= 1'b0;
         track_range_ff <= 1'b0;
         thr_valid_ff   <= '0;
         stat_valid_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= ent_rd_en;
         thr_valid_ff  <= thr_valid_in;
         stat_valid_ff <= stat_valid_in;
         if (csr_write_enable) begin
            track_range_ff <= csr_write_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff    <= req_payload;
         h_base_ff  <= ENT_AW'(ENT_AW'(req_payload.head) * ENT_AW'(DIM));
         t_base_ff  <= ENT_AW'(ENT_AW'(req_payload.tail) * ENT_AW'(DIM));
         r_base_ff  <= REL_TAW'(REL_TAW'(req_payload.relation) * REL_TAW'(DIM));
         head_ok_ff <= 32'(req_payload.head) < ENTITIES;
         tail_ok_ff <= 32'(req_payload.tail) < ENTITIES;
         rel_ok_ff  <= 32'(req_payload.relation) < RELATIONS;
      end
      idx_ff    <= idx_in;
      pend_ff   <= pend_in;
      accept_ff <= accept_in;
      if (load_rsp) begin
         rsp_ff <= pend_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !dist_busy && !rd_valid_ff)
      else $error("accumulator active while idle");

   a_no_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN || state_ff == ST_DRAIN) |-> !ent_wr_en && !rel_wr_en)
      else $error("embedding write during distance sweep");

   a_stat_write_state: assert property (@(posedge clock) disable iff (reset)
      stat_wr_en |-> (state_ff == ST_EXEC || state_ff == ST_UPDATE))
      else $error("statistics row written outside its slots");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised without leaving the output state");
`endif

endmodule
